### design/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the iBUS frame decoder.
// ----------------------------------------------------------------------------
package ifd_pkg;

  // Default geometry of a frame.
  localparam int unsigned DEF_CHANNELS    = 14;
  localparam int unsigned DEF_FRAME_BYTES = 32;

  // Fixed widths of the byte counter, channel index and words.
  localparam int unsigned POS_W   = 6;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Reset values of the configuration registers.
  localparam logic [7:0] LENGTH_HDR_RESET  = 8'd32;
  localparam logic [7:0] COMMAND_HDR_RESET = 8'd64;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_HDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_HDR = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_HEADER   = 2'd2,
    ST_CHECKSUM = 2'd3
  } ifd_status_e;

  typedef enum logic [1:0] {
    DR_IDLE,
    DR_FETCH,
    DR_SHOW
  } ifd_drain_state_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } ifd_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  channel_index;
    logic [WORD_W-1:0] channel_value;
    logic              last_result;
  } ifd_out_t;

  // Outcome of a frame, handed from the byte stage to the result sequencer.
  typedef struct packed {
    logic        valid;
    ifd_status_e status;
  } ifd_verdict_t;

endpackage

### design/ifd_ram.sv
// ----------------------------------------------------------------------------
// ifd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ifd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 14,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ifd_ingest.sv
// ----------------------------------------------------------------------------
// ifd_ingest
// Byte stage: counts bytes, sums, checks length, headers and checksum, writes channel words.
// ----------------------------------------------------------------------------
module ifd_ingest #(
  parameter int unsigned CHANNELS    = ifd_pkg::DEF_CHANNELS,
  parameter int unsigned FRAME_BYTES = ifd_pkg::DEF_FRAME_BYTES,
  parameter int unsigned AW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  ifd_pkg::ifd_in_t      item_i,
  input  logic [7:0]            length_hdr_i,
  input  logic [7:0]            command_hdr_i,
  output logic                  wr_en_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [ifd_pkg::WORD_W-1:0] wr_data_o,
  output ifd_pkg::ifd_verdict_t verdict_o
);
  import ifd_pkg::*;

  localparam logic [POS_W-1:0]   FB_POS  = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0]   SUM_END = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0]   POS_MAX = POS_W'(FRAME_BYTES + 1);
  localparam logic [POS_W-2:0]   CH_LIM  = (POS_W - 1)'(CHANNELS);

  logic [POS_W-1:0]  pos_q, pos_d, pos_u;
  logic [WORD_W-1:0] sum_q, sum_d, sum_u;
  logic              hdr_q, hdr_d, hdr_u;
  logic [7:0]        low_q, low_d;
  logic [WORD_W-1:0] cks_q, cks_d, cks_u;
  logic [POS_W-1:0]  ch_off;
  logic [POS_W-2:0]  ch_num;
  logic [7:0]        b;

  assign b      = item_i.frame_byte;
  assign ch_off = pos_q - POS_W'(2);
  assign ch_num = ch_off[POS_W-1:1];

  always_comb begin
    pos_u     = pos_q;
    sum_u     = sum_q;
    hdr_u     = hdr_q;
    low_d     = low_q;
    cks_u     = cks_q;
    wr_en_o   = 1'b0;
    wr_addr_o = ch_num[AW-1:0];
    wr_data_o = {b, low_q};
    verdict_o = '{valid: 1'b0, status: ST_OK};

    if (pos_q < FB_POS) begin
      if (pos_q == POS_W'(0) && b != length_hdr_i) begin
        hdr_u = 1'b1;
      end
      if (pos_q == POS_W'(1) && b != command_hdr_i) begin
        hdr_u = 1'b1;
      end
      if (pos_q < SUM_END) begin
        sum_u = sum_q + WORD_W'(b);
        if (pos_q >= POS_W'(2) && ch_num < CH_LIM) begin
          if (!ch_off[0]) begin
            low_d = b;
          end else begin
            wr_en_o = accept_i;
          end
        end
      end else if (pos_q == SUM_END) begin
        cks_u = {cks_q[15:8], b};
      end else begin
        cks_u = {b, cks_q[7:0]};
      end
    end
    pos_u = (pos_q == POS_MAX) ? POS_MAX : pos_q + POS_W'(1);

    // Checks in priority order: length, header, then checksum.
    if (pos_u != FB_POS) begin
      verdict_o.status = ST_LENGTH;
    end else if (hdr_u) begin
      verdict_o.status = ST_HEADER;
    end else if (~sum_u != cks_u) begin
      verdict_o.status = ST_CHECKSUM;
    end
    verdict_o.valid = accept_i && item_i.end_of_frame;

    if (!accept_i) begin
      pos_d = pos_q;
      sum_d = sum_q;
      hdr_d = hdr_q;
      low_d = low_q;
      cks_d = cks_q;
    end else if (item_i.end_of_frame) begin
      pos_d = '0;
      sum_d = '0;
      hdr_d = 1'b0;
      low_d = '0;
      cks_d = '0;
    end else begin
      pos_d = pos_u;
      sum_d = sum_u;
      hdr_d = hdr_u;
      cks_d = cks_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      hdr_q <= 1'b0;
      low_q <= '0;
      cks_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      hdr_q <= hdr_d;
      low_q <= low_d;
      cks_q <= cks_d;
    end
  end

endmodule

### design/ifd_drain.sv
// ----------------------------------------------------------------------------
// ifd_drain
// Result sequencer: reads the channel store back and presents results.
// ----------------------------------------------------------------------------
module ifd_drain #(
  parameter int unsigned CHANNELS    = ifd_pkg::DEF_CHANNELS,
  parameter int unsigned FRAME_BYTES = ifd_pkg::DEF_FRAME_BYTES,
  parameter int unsigned AW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ifd_pkg::ifd_verdict_t verdict_i,
  output logic                  busy_o,
  output logic                  rd_en_o,
  output logic [AW-1:0]         rd_addr_o,
  input  logic [ifd_pkg::WORD_W-1:0] rd_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ifd_pkg::ifd_out_t     out_data_o
);
  import ifd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(CHANNELS - 1);
  localparam logic [IDX_W+2:0] FB_LIM  = (IDX_W + 3)'(FRAME_BYTES);

  ifd_drain_state_e state_q, state_d;
  logic [IDX_W-1:0] ch_q, ch_d;
  ifd_out_t         out_q, out_d;
  logic             in_frame;

  // A channel whose word would overlap the checksum field reads as zero.
  assign in_frame = ({2'b00, ch_q, 1'b0} + (IDX_W + 3)'(6)) <= FB_LIM;

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    out_d     = out_q;
    rd_en_o   = 1'b0;
    rd_addr_o = ch_q[AW-1:0];

    case (state_q)
      DR_IDLE: begin
        if (verdict_i.valid) begin
          if (verdict_i.status == ST_OK) begin
            ch_d      = '0;
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            state_d   = DR_FETCH;
          end else begin
            out_d   = '{status: verdict_i.status, channel_index: '0,
                        channel_value: '0, last_result: 1'b1};
            state_d = DR_SHOW;
          end
        end
      end
      DR_FETCH: begin
        out_d   = '{status: ST_OK, channel_index: ch_q,
                    channel_value: in_frame ? rd_data_i : '0,
                    last_result: ch_q == LAST_CH};
        state_d = DR_SHOW;
      end
      DR_SHOW: begin
        if (out_ready_i) begin
          if (out_q.last_result) begin
            state_d = DR_IDLE;
          end else begin
            ch_d      = ch_q + IDX_W'(1);
            rd_en_o   = 1'b1;
            rd_addr_o = ch_d[AW-1:0];
            state_d   = DR_FETCH;
          end
        end
      end
      default: begin
        state_d = DR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DR_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign busy_o      = state_q != DR_IDLE;
  assign out_valid_o = state_q == DR_SHOW;
  assign out_data_o  = out_q;

endmodule

### design/ibus_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// ibus_frame_decoder_top
// iBUS receiver frame decoder: bytes in, fourteen channel results out.
// ----------------------------------------------------------------------------
// The decoder takes one frame byte per input item, with end_of_frame set on
// the frame's final byte. Bytes are taken at one per clock while no results
// are pending; a non-final byte causes no result. On the final byte the frame
// is checked for length, then both header bytes against the two configuration
// registers, then the checksum (0xFFFF minus the sum of the first
// FRAME_BYTES-2 bytes against the little-endian word in the last two bytes).
// A failed check gives one error result with last_result set. A good frame
// gives CHANNELS results, one per channel, read back from the channel store
// RAM; each result is read from the RAM and then held on the output until
// the consumer raises out_ready_i, and in_ready_o stays low until the
// frame's last result has been taken. Channel words are written
// into the store as their high byte arrives, so the store and the result
// readout never touch the RAM in the same cycle. Configuration writes are
// always accepted and should be made only while the decoder is idle.
// ----------------------------------------------------------------------------
module ibus_frame_decoder_top #(
  parameter int unsigned CHANNELS    = ifd_pkg::DEF_CHANNELS,
  parameter int unsigned FRAME_BYTES = ifd_pkg::DEF_FRAME_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ifd_pkg::ifd_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ifd_pkg::ifd_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);
  import ifd_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]        length_hdr_q;
  logic [7:0]        command_hdr_q;
  logic              accept;
  logic              busy;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  ifd_verdict_t      verdict;

  // Configuration registers: the expected length and command header bytes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_hdr_q  <= LENGTH_HDR_RESET;
      command_hdr_q <= COMMAND_HDR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LENGTH_HDR:  length_hdr_q  <= cfg_data_i;
        REG_COMMAND_HDR: command_hdr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Bytes are held off while a frame's results are still being delivered.
  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  ifd_ingest #(
    .CHANNELS    (CHANNELS),
    .FRAME_BYTES (FRAME_BYTES),
    .AW          (AW)
  ) u_ingest (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (in_data_i),
    .length_hdr_i  (length_hdr_q),
    .command_hdr_i (command_hdr_q),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .verdict_o     (verdict)
  );

  // Channel store: one 16-bit word per channel.
  ifd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ifd_drain #(
    .CHANNELS    (CHANNELS),
    .FRAME_BYTES (FRAME_BYTES),
    .AW          (AW)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .verdict_i   (verdict),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
